// ===== src/fts_pkg.sv =====
// Package for the fixed-timestep tick generator
// Shared widths, command and speed codes, reset constant
// No dependencies
package fts_pkg;

  // field widths
  localparam int CMD_W     = 3;
  localparam int DUR_W     = 32;
  localparam int DELTA_W   = 32;
  localparam int MAXT_IN_W = 16;
  localparam int PROD_W    = DUR_W + MAXT_IN_W;
  localparam int CNT_W     = 64;
  localparam int PEND_W    = 48;
  localparam int SPEED_W   = 2;
  localparam int ADD_W     = DELTA_W + 2;

  // parameter defaults
  localparam int ACCUM_WIDTH_DEF    = 48;
  localparam int MAX_TICK_WIDTH_DEF = 16;

  // reset value of the tick length register
  localparam logic [DUR_W-1:0] TICK_DUR_RESET = 32'd16667;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STEP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SPEED   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

  // speed codes
  localparam logic [SPEED_W-1:0] SPEED_PAUSED = 2'd0;
  localparam logic [SPEED_W-1:0] SPEED_NORMAL = 2'd1;
  localparam logic [SPEED_W-1:0] SPEED_FAST   = 2'd2;
  localparam logic [SPEED_W-1:0] SPEED_VFAST  = 2'd3;

  // start and finish of a serial unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== src/fts_mul.sv =====
// Bit-serial shift-add multiplier: tick length times tick cap
// One multiplier bit per cycle, MSB first
// Depends on fts_pkg
module fts_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  fts_pkg::unit_ctl_t              ctl,
  input  logic [fts_pkg::DUR_W-1:0]       mcand,
  input  logic [fts_pkg::MAXT_IN_W-1:0]   mplier,
  output logic [fts_pkg::PROD_W-1:0]      prod,
  output fts_pkg::unit_stat_t             stat
);

  localparam int CW = $clog2(fts_pkg::MAXT_IN_W + 1);

  logic [CW-1:0]                    cnt;
  logic [fts_pkg::MAXT_IN_W-1:0]    mreg;
  logic                             busy;
  logic                             done;

  // control: bit counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(fts_pkg::MAXT_IN_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift the product, add the multiplicand on a set bit
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod <= '0;
      mreg <= mplier;
    end else if (busy) begin
      prod <= {prod[fts_pkg::PROD_W-2:0], 1'b0}
              + (mreg[fts_pkg::MAXT_IN_W-1] ? fts_pkg::PROD_W'(mcand) : '0);
      mreg <= {mreg[fts_pkg::MAXT_IN_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== src/fts_div.sv =====
// Bit-serial restoring divider: accumulator over tick length
// One quotient bit per cycle through a 33-bit compare and subtract
// Depends on fts_pkg
module fts_div #(
  parameter int ACCUM_WIDTH = fts_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fts_pkg::unit_ctl_t            ctl,
  input  logic [ACCUM_WIDTH-1:0]        dividend,
  input  logic [fts_pkg::DUR_W-1:0]     divisor,
  output logic [ACCUM_WIDTH-1:0]        quot,
  output logic [fts_pkg::DUR_W-1:0]     rem,
  output fts_pkg::unit_stat_t           stat
);

  localparam int CW = $clog2(ACCUM_WIDTH + 1);

  logic [CW-1:0]                 cnt;
  logic                          busy;
  logic                          done;
  logic [fts_pkg::DUR_W-1:0]     dreg;
  logic [fts_pkg::DUR_W:0]       trial;
  logic                          ge;

  // next partial remainder takes the dividend MSB
  assign trial = {rem, quot[ACCUM_WIDTH-1]};
  assign ge    = (trial >= {1'b0, dreg});

  // control: bit counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(ACCUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quot <= dividend;
      rem  <= '0;
      dreg <= divisor;
    end else if (busy) begin
      quot <= {quot[ACCUM_WIDTH-2:0], ge};
      rem  <= ge ? fts_pkg::DUR_W'(trial - {1'b0, dreg}) : trial[fts_pkg::DUR_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== src/fixed_timestep_tick_generator.sv =====
// Sequence: an advance with nonzero delta and cap on a running clock goes from accept through add,
// the serial multiply and a compare, then straight to the count step when the tick cap is reached
// or through the serial divider (one quotient bit per cycle) otherwise; others go straight to output.
// Throughput: one command at a time; the next is taken once the result is in the output
// register, even while that result still waits to be taken.
// Reset: synchronous; speed normal, accumulator and tick counter zero, tick length 16667 us.
// Top level of the fixed-timestep tick generator; depends on fts_pkg, fts_mul, fts_div
module fixed_timestep_tick_generator #(
  parameter int ACCUM_WIDTH    = fts_pkg::ACCUM_WIDTH_DEF,
  parameter int MAX_TICK_WIDTH = fts_pkg::MAX_TICK_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fts_pkg::DUR_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fts_pkg::CMD_W-1:0]         cmd,
  input  logic [fts_pkg::DELTA_W-1:0]       delta_us,
  input  logic [fts_pkg::MAXT_IN_W-1:0]     max_ticks,
  input  logic [fts_pkg::SPEED_W-1:0]       speed_sel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fts_pkg::MAXT_IN_W-1:0]     ticks_due,
  output logic                              step_taken,
  output logic [fts_pkg::CNT_W-1:0]         tick_count_out,
  output logic [fts_pkg::PEND_W-1:0]        pending_us,
  output logic [fts_pkg::SPEED_W-1:0]       speed_now
);

  localparam int MW = fts_pkg::MAXT_IN_W;
  localparam int CMPW = (ACCUM_WIDTH > fts_pkg::PROD_W) ? ACCUM_WIDTH : fts_pkg::PROD_W;
  localparam int EXTW = (ACCUM_WIDTH > fts_pkg::PEND_W) ? ACCUM_WIDTH : fts_pkg::PEND_W;
  localparam logic [MW-1:0] MAXT_MASK =
    (MAX_TICK_WIDTH >= MW) ? {MW{1'b1}} : MW'((64'd1 << MAX_TICK_WIDTH) - 64'd1);
  localparam logic [EXTW-1:0] PEND_MAX = EXTW'({fts_pkg::PEND_W{1'b1}});

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_CNT  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]                        state;
  logic [fts_pkg::SPEED_W-1:0]       speed;
  logic [fts_pkg::SPEED_W-1:0]       resume_speed;
  logic [ACCUM_WIDTH-1:0]            accum;
  logic [fts_pkg::CNT_W-1:0]         tick_counter;
  logic [fts_pkg::DUR_W-1:0]         tick_dur;

  logic [fts_pkg::ADD_W-1:0]         add_q;
  logic [MW-1:0]                     maxt_q;
  logic [MW-1:0]                     emitted_q;
  logic                              stepped_q;

  logic                              accept;
  logic                              out_free;
  logic [MW-1:0]                     maxt_in;
  logic                              adv_live;
  logic [fts_pkg::ADD_W-1:0]         add_in;
  logic [ACCUM_WIDTH:0]              sum;
  logic [CMPW-1:0]                   acc_cmp;
  logic [CMPW-1:0]                   prod_cmp;
  logic                              capped;
  logic [EXTW-1:0]                   acc_ext;

  fts_pkg::unit_ctl_t                mul_ctl;
  fts_pkg::unit_ctl_t                div_ctl;
  fts_pkg::unit_stat_t               mul_stat;
  fts_pkg::unit_stat_t               div_stat;
  logic [fts_pkg::PROD_W-1:0]        prod;
  logic [ACCUM_WIDTH-1:0]            quot;
  logic [fts_pkg::DUR_W-1:0]         rem;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign maxt_in  = max_ticks & MAXT_MASK;
  assign adv_live = (speed != fts_pkg::SPEED_PAUSED) && (delta_us != '0) && (maxt_in != '0);

  // elapsed time scaled by x1, x2 or x4
  always_comb begin
    unique case (speed)
      fts_pkg::SPEED_FAST:  add_in = {1'b0, delta_us, 1'b0};
      fts_pkg::SPEED_VFAST: add_in = {delta_us, 2'b00};
      default:              add_in = {2'b00, delta_us};
    endcase
  end

  // saturating accumulate, cap check against cap times tick length
  assign sum      = {1'b0, accum} + (ACCUM_WIDTH + 1)'(add_q);
  assign acc_cmp  = CMPW'(accum);
  assign prod_cmp = CMPW'(prod);
  assign capped   = (acc_cmp >= prod_cmp);
  assign acc_ext  = EXTW'(accum);

  assign mul_ctl.start = (state == ST_ADD);
  assign div_ctl.start = (state == ST_CMP) && !capped;

  fts_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .mcand  (tick_dur),
    .mplier (maxt_q),
    .prod   (prod),
    .stat   (mul_stat)
  );

  fts_div #(
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (accum),
    .divisor  (tick_dur),
    .quot     (quot),
    .rem      (rem),
    .stat     (div_stat)
  );

  // sequencer and clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      speed        <= fts_pkg::SPEED_NORMAL;
      resume_speed <= fts_pkg::SPEED_NORMAL;
      accum        <= '0;
      tick_counter <= '0;
      tick_dur     <= fts_pkg::TICK_DUR_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tick_dur <= (cfg_wr_data == '0) ? fts_pkg::DUR_W'(1) : cfg_wr_data;
      end
      // result beat goes up from the out state, drops when taken
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ((cmd == fts_pkg::CMD_ADVANCE) && adv_live) ? ST_ADD : ST_OUT;
            unique case (cmd)
              fts_pkg::CMD_ADVANCE: begin
              end
              fts_pkg::CMD_STEP: begin
                if (speed == fts_pkg::SPEED_PAUSED) begin
                  tick_counter <= tick_counter + fts_pkg::CNT_W'(1);
                end
              end
              fts_pkg::CMD_PAUSE: begin
                if (speed != fts_pkg::SPEED_PAUSED) begin
                  resume_speed <= speed;
                  speed        <= fts_pkg::SPEED_PAUSED;
                end
              end
              fts_pkg::CMD_RESUME: begin
                if (speed == fts_pkg::SPEED_PAUSED) begin
                  speed <= (resume_speed == fts_pkg::SPEED_PAUSED) ?
                           fts_pkg::SPEED_NORMAL : resume_speed;
                end
              end
              fts_pkg::CMD_SPEED: begin
                speed <= speed_sel;
                if (speed_sel != fts_pkg::SPEED_PAUSED) begin
                  resume_speed <= speed_sel;
                end
              end
              fts_pkg::CMD_CLEAR: begin
                speed        <= fts_pkg::SPEED_NORMAL;
                resume_speed <= fts_pkg::SPEED_NORMAL;
                accum        <= '0;
                tick_counter <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADD: begin
          accum <= sum[ACCUM_WIDTH] ? {ACCUM_WIDTH{1'b1}} : sum[ACCUM_WIDTH-1:0];
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (capped) begin
            accum <= ACCUM_WIDTH'(acc_cmp - prod_cmp);
            state <= ST_CNT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            accum <= ACCUM_WIDTH'(rem);
            state <= ST_CNT;
          end
        end
        ST_CNT: begin
          tick_counter <= tick_counter + fts_pkg::CNT_W'(emitted_q);
          state        <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // per-command payload
  always_ff @(posedge clk) begin
    if (accept) begin
      add_q     <= add_in;
      maxt_q    <= maxt_in;
      emitted_q <= '0;
      stepped_q <= (cmd == fts_pkg::CMD_STEP) && (speed == fts_pkg::SPEED_PAUSED);
    end
    if ((state == ST_CMP) && capped) begin
      emitted_q <= maxt_q;
    end
    if ((state == ST_DIV) && div_stat.done) begin
      emitted_q <= quot[MW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      ticks_due      <= emitted_q;
      step_taken     <= stepped_q;
      tick_count_out <= tick_counter;
      pending_us     <= (acc_ext > PEND_MAX) ? {fts_pkg::PEND_W{1'b1}}
                                             : acc_ext[fts_pkg::PEND_W-1:0];
      speed_now      <= speed;
    end
  end

  // emitted ticks never exceed the cap
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CNT) |-> (emitted_q <= maxt_q))
    else $error("emitted ticks above cap");

  // leftover is below one tick unless the cap was hit
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CNT) |-> ((accum < ACCUM_WIDTH'(tick_dur)) || (emitted_q == maxt_q)))
    else $error("leftover time holds a whole tick");

  // an accepted beat always leaves idle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("beat accepted without leaving idle");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider done outside divide state");

endmodule

// ===== tb/tick_gen_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the fixed-timestep tick generator: predicts every command beat
// and compares each result beat field by field; depends on fts_pkg only
module tick_gen_checker #(
  parameter int ACCUM_WIDTH    = fts_pkg::ACCUM_WIDTH_DEF,
  parameter int MAX_TICK_WIDTH = fts_pkg::MAX_TICK_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fts_pkg::DUR_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [fts_pkg::CMD_W-1:0]     cmd,
  input  logic [fts_pkg::DELTA_W-1:0]   delta_us,
  input  logic [fts_pkg::MAXT_IN_W-1:0] max_ticks,
  input  logic [fts_pkg::SPEED_W-1:0]   speed_sel,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [fts_pkg::MAXT_IN_W-1:0] ticks_due,
  input  logic                          step_taken,
  input  logic [fts_pkg::CNT_W-1:0]     tick_count_out,
  input  logic [fts_pkg::PEND_W-1:0]    pending_us,
  input  logic [fts_pkg::SPEED_W-1:0]   speed_now,
  output int                            fail_count,
  output int                            outstanding
);

  typedef struct packed {
    logic [fts_pkg::MAXT_IN_W-1:0] ticks;
    logic                          step;
    logic [fts_pkg::CNT_W-1:0]     count;
    logic [fts_pkg::PEND_W-1:0]    pend;
    logic [fts_pkg::SPEED_W-1:0]   speed;
  } clock_report_t;

  // shadow copy of the clock state
  logic [fts_pkg::SPEED_W-1:0] clock_speed;
  logic [fts_pkg::SPEED_W-1:0] held_speed;
  logic [63:0]                 sim_accum_us;
  logic [fts_pkg::CNT_W-1:0]   tick_total;
  logic [fts_pkg::DUR_W-1:0]   tick_len;

  clock_report_t expected_reports[$];
  clock_report_t want;

  // apply one command to the shadow state and return the report it gives
  function automatic clock_report_t apply_command(
      input logic [fts_pkg::CMD_W-1:0] op,
      input logic [fts_pkg::DELTA_W-1:0] delta,
      input logic [fts_pkg::MAXT_IN_W-1:0] maxt_in,
      input logic [fts_pkg::SPEED_W-1:0] sel);
    clock_report_t r;
    logic [63:0] scaled, lim, dur, due, cap, emitted, pend_max;
    emitted = '0;
    r.step = 1'b0;
    cap = {{(64-fts_pkg::MAXT_IN_W){1'b0}}, maxt_in} & ((64'd1 << MAX_TICK_WIDTH) - 64'd1);
    case (op)
      fts_pkg::CMD_ADVANCE: begin
        if (clock_speed != fts_pkg::SPEED_PAUSED && delta != '0 && cap != '0) begin
          case (clock_speed)
            fts_pkg::SPEED_NORMAL: scaled = {32'b0, delta};
            fts_pkg::SPEED_FAST:   scaled = {32'b0, delta} << 1;
            fts_pkg::SPEED_VFAST:  scaled = {32'b0, delta} << 2;
            default:               scaled = '0;
          endcase
          lim = (64'd1 << ACCUM_WIDTH) - 64'd1;
          dur = {32'b0, tick_len};
          // saturate rather than wrap
          if (scaled > lim - sim_accum_us) sim_accum_us = lim;
          else sim_accum_us = sim_accum_us + scaled;
          due = sim_accum_us / dur;
          emitted = (due < cap) ? due : cap;
          sim_accum_us = sim_accum_us - emitted * dur;
          tick_total = tick_total + emitted;
        end
      end
      fts_pkg::CMD_STEP: begin
        if (clock_speed == fts_pkg::SPEED_PAUSED) begin
          tick_total = tick_total + 64'd1;
          r.step = 1'b1;
        end
      end
      fts_pkg::CMD_PAUSE: begin
        if (clock_speed != fts_pkg::SPEED_PAUSED) begin
          held_speed = clock_speed;
          clock_speed = fts_pkg::SPEED_PAUSED;
        end
      end
      fts_pkg::CMD_RESUME: begin
        if (clock_speed == fts_pkg::SPEED_PAUSED)
          clock_speed = (held_speed == fts_pkg::SPEED_PAUSED) ? fts_pkg::SPEED_NORMAL
                                                               : held_speed;
      end
      fts_pkg::CMD_SPEED: begin
        clock_speed = sel;
        if (sel != fts_pkg::SPEED_PAUSED) held_speed = sel;
      end
      fts_pkg::CMD_CLEAR: begin
        clock_speed = fts_pkg::SPEED_NORMAL;
        held_speed = fts_pkg::SPEED_NORMAL;
        sim_accum_us = '0;
        tick_total = '0;
      end
      default: ;
    endcase
    pend_max = (64'd1 << fts_pkg::PEND_W) - 64'd1;
    r.ticks = emitted[fts_pkg::MAXT_IN_W-1:0];
    r.count = tick_total;
    r.pend = (sim_accum_us > pend_max) ? pend_max[fts_pkg::PEND_W-1:0]
                                       : sim_accum_us[fts_pkg::PEND_W-1:0];
    r.speed = clock_speed;
    return r;
  endfunction

  // one field of a result beat against its prediction
  task automatic check_field(input string fname, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t tick_gen_checker: %s expected %0h got %0h",
               $time, fname, want_v, got_v);
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      clock_speed = fts_pkg::SPEED_NORMAL;
      held_speed = fts_pkg::SPEED_NORMAL;
      sim_accum_us = '0;
      tick_total = '0;
      tick_len = fts_pkg::TICK_DUR_RESET;
      expected_reports.delete();
    end else begin
      // a zero length is stored as one
      if (cfg_wr_en)
        tick_len = (cfg_wr_data == '0) ? {{(fts_pkg::DUR_W-1){1'b0}}, 1'b1} : cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          fail_count++;
          $display("%0t tick_gen_checker: expected no result beat, got ticks %0h count %0h",
                   $time, ticks_due, tick_count_out);
        end else begin
          want = expected_reports.pop_front();
          check_field("ticks_due", 64'(want.ticks), 64'(ticks_due));
          check_field("step_taken", 64'(want.step), 64'(step_taken));
          check_field("tick_count_out", want.count, tick_count_out);
          check_field("pending_us", 64'(want.pend), 64'(pending_us));
          check_field("speed_now", 64'(want.speed), 64'(speed_now));
        end
      end
      if (in_valid && in_ready)
        expected_reports.push_back(apply_command(cmd, delta_us, max_ticks, speed_sel));
    end
    outstanding = expected_reports.size();
  end

endmodule

// ===== tb/fixed_timestep_tick_generator_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the fixed-timestep tick generator; the result checker
// sits beside the block; depends on fts_pkg, tick_gen_checker and the block itself
module fixed_timestep_tick_generator_tb;

  localparam int ACC_W = fts_pkg::ACCUM_WIDTH_DEF;
  localparam int MT_W  = fts_pkg::MAX_TICK_WIDTH_DEF;

  // command codes the block treats as no-ops
  localparam logic [fts_pkg::CMD_W-1:0] CMD_RSVD_LO = 3'd6;
  localparam logic [fts_pkg::CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  // full-rate advances at unit tick length that grow the accumulator; random blocks and beats per block
  localparam int CLIMB_ITEMS = 40;
  localparam int RAND_BLOCKS = 8;
  localparam int BLOCK_ITEMS = 110;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [fts_pkg::DUR_W-1:0]     cfg_wr_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [fts_pkg::CMD_W-1:0]     cmd = fts_pkg::CMD_ADVANCE;
  logic [fts_pkg::DELTA_W-1:0]   delta_us = '0;
  logic [fts_pkg::MAXT_IN_W-1:0] max_ticks = '0;
  logic [fts_pkg::SPEED_W-1:0]   speed_sel = fts_pkg::SPEED_NORMAL;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [fts_pkg::MAXT_IN_W-1:0] ticks_due;
  logic                          step_taken;
  logic [fts_pkg::CNT_W-1:0]     tick_count_out;
  logic [fts_pkg::PEND_W-1:0]    pending_us;
  logic [fts_pkg::SPEED_W-1:0]   speed_now;

  int fail_count;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [fts_pkg::DUR_W-1:0] cur_len = fts_pkg::TICK_DUR_RESET;

  fixed_timestep_tick_generator #(
    .ACCUM_WIDTH(ACC_W),
    .MAX_TICK_WIDTH(MT_W)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .delta_us(delta_us), .max_ticks(max_ticks), .speed_sel(speed_sel),
    .out_valid(out_valid), .out_ready(out_ready),
    .ticks_due(ticks_due), .step_taken(step_taken), .tick_count_out(tick_count_out),
    .pending_us(pending_us), .speed_now(speed_now)
  );

  tick_gen_checker #(
    .ACCUM_WIDTH(ACC_W),
    .MAX_TICK_WIDTH(MT_W)
  ) tick_check (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .delta_us(delta_us), .max_ticks(max_ticks), .speed_sel(speed_sel),
    .out_valid(out_valid), .out_ready(out_ready),
    .ticks_due(ticks_due), .step_taken(step_taken), .tick_count_out(tick_count_out),
    .pending_us(pending_us), .speed_now(speed_now),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // hard stop if the block hangs
  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin idle_pct = 53; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 53; end
      IDLE_BOTH:     begin idle_pct = 8;  stall_pct = 8;  end
      default:       begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // drive one command beat and hold it until taken
  task automatic send_cmd(input logic [fts_pkg::CMD_W-1:0] op,
                          input logic [fts_pkg::DELTA_W-1:0] d,
                          input logic [fts_pkg::MAXT_IN_W-1:0] m,
                          input logic [fts_pkg::SPEED_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    delta_us <= d;
    max_ticks <= m;
    speed_sel <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every result has drained
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tick_len(input logic [fts_pkg::DUR_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = (v == '0) ? 32'd1 : v;
  endtask

  // random command with mixed field distributions
  task automatic send_random_cmd;
    logic [fts_pkg::CMD_W-1:0]     op;
    logic [fts_pkg::DELTA_W-1:0]   d;
    logic [fts_pkg::MAXT_IN_W-1:0] m;
    int r;
    r = $urandom_range(99);
    if (r < 50) op = fts_pkg::CMD_ADVANCE;
    else if (r < 58) op = fts_pkg::CMD_STEP;
    else if (r < 66) op = fts_pkg::CMD_PAUSE;
    else if (r < 76) op = fts_pkg::CMD_RESUME;
    else if (r < 88) op = fts_pkg::CMD_SPEED;
    else if (r < 94) op = fts_pkg::CMD_CLEAR;
    else op = $urandom_range(1) ? CMD_RSVD_HI : CMD_RSVD_LO;
    r = $urandom_range(99);
    if (r < 8) d = '0;
    else if (r < 40) d = $urandom_range(100000);
    else if (r < 70) d = $urandom();
    else if (r < 80) d = '1;
    else d = $urandom_range(cur_len);
    r = $urandom_range(99);
    if (r < 6) m = '0;
    else if (r < 40) m = fts_pkg::MAXT_IN_W'($urandom_range(8, 1));
    else if (r < 70) m = fts_pkg::MAXT_IN_W'($urandom());
    else if (r < 80) m = '1;
    else m = fts_pkg::MAXT_IN_W'($urandom_range(300, 1));
    send_cmd(op, d, m, fts_pkg::SPEED_W'($urandom_range(3)));
  endtask

  initial begin
    logic [fts_pkg::DUR_W-1:0] len;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    set_idling(IDLE_NONE);

    // directed: no-op advances, step, pause and resume rules, speed changes, reserved codes, clear
    send_cmd(fts_pkg::CMD_ADVANCE, 32'd0, 16'd5, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'd40000, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'd50000, 16'hFFFF, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_STEP, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_PAUSE, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_PAUSE, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'd100000, 16'd10, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_STEP, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_RESUME, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_RESUME, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_SPEED, 32'd0, 16'd0, fts_pkg::SPEED_FAST);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'hFFFF_FFFF, 16'd1, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_SPEED, 32'd0, 16'd0, fts_pkg::SPEED_VFAST);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'hFFFF_FFFF, 16'hFFFF, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_SPEED, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'd70000, 16'd9, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_RESUME, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_PAUSE, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_SPEED, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_RESUME, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);
    send_cmd(CMD_RSVD_LO, $urandom(), fts_pkg::MAXT_IN_W'($urandom()),
             fts_pkg::SPEED_W'($urandom_range(3)));
    send_cmd(CMD_RSVD_HI, $urandom(), fts_pkg::MAXT_IN_W'($urandom()),
             fts_pkg::SPEED_W'($urandom_range(3)));
    send_cmd(fts_pkg::CMD_ADVANCE, 32'd20000, 16'd3, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, fts_pkg::SPEED_VFAST);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'd16667, 16'd1, fts_pkg::SPEED_PAUSED);

    // unit tick length at four times speed, tiny caps: grow the accumulator
    write_tick_len('0);
    send_cmd(fts_pkg::CMD_SPEED, 32'd0, 16'd0, fts_pkg::SPEED_VFAST);
    for (int i = 0; i < CLIMB_ITEMS; i++)
      send_cmd(fts_pkg::CMD_ADVANCE, 32'hFFFF_FFFF,
               fts_pkg::MAXT_IN_W'($urandom_range(3, 1)),
               fts_pkg::SPEED_W'($urandom_range(3)));
    send_cmd(fts_pkg::CMD_ADVANCE, 32'd1, 16'hFFFF, fts_pkg::SPEED_PAUSED);
    // longest tick length against a large accumulator
    write_tick_len('1);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'hFFFF_FFFF, 16'hFFFF, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_ADVANCE, 32'hFFFF_FFFF, 16'hFFFF, fts_pkg::SPEED_PAUSED);
    send_cmd(fts_pkg::CMD_CLEAR, 32'd0, 16'd0, fts_pkg::SPEED_PAUSED);

    // random blocks, each with its own tick length and idling mix
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      case (blk)
        0: len = '1;
        1: len = 32'd1;
        2: len = fts_pkg::TICK_DUR_RESET;
        3: len = '0;
        4: len = $urandom_range(200, 2);
        5: len = $urandom();
        6: len = $urandom_range(50000, 1000);
        default: len = 32'd3;
      endcase
      write_tick_len(len);
      set_idling(idle_mode_t'(blk % 4));
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        // now and then let everything drain before the next beat
        if ($urandom_range(99) == 0) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (outstanding != 0) @(negedge clk);
        end
        send_random_cmd();
      end
    end

    // wind down
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (ACC_W + 30) @(negedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
